// ===== sv/apts_pkg.sv =====
// Package for the aging priority task scheduler.
// Holds shared constants and item mode codes.
// No dependencies.
package apts_pkg;

    localparam int TASK_SLOTS_DEF = 16;
    localparam int PRIO_BITS_DEF  = 8;
    localparam int SKIP_BITS      = 16;
    localparam int MODE_BITS      = 3;
    localparam int REQ_SLOT_BITS  = 4;
    localparam int REQ_PRIO_BITS  = 8;

    // Item mode codes.
    localparam logic [MODE_BITS-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_SWITCH = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_BLOCK  = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_ADD    = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_REMOVE = 3'd4;

endpackage

// ===== sv/apts_table.sv =====
// Task table memory: one synchronous RAM holding static priority,
// dynamic priority and skip count per slot. Depends on apts_pkg.
module apts_table
    import apts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF,
    parameter int PRIO_BITS  = PRIO_BITS_DEF,
    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1,
    localparam int EW = 2 * PRIO_BITS + SKIP_BITS
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [SW-1:0] wr_addr,
    input  logic [EW-1:0] wr_data,
    input  logic [SW-1:0] rd_addr,
    output logic [EW-1:0] rd_data
);

    logic [EW-1:0] mem [TASK_SLOTS];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/aging_priority_task_scheduler_top.sv =====
// Top level of the aging priority task scheduler.
// Depends on apts_pkg and apts_table.
//
// Usage: items arrive on the s_axis channel (tdata: mode, task_req,
// priority_req), one result per item leaves on m_axis (tdata: next_task,
// next_is_idle, switched). Add and remove items skip the table scan. Tick,
// switch and block items walk the task table one slot per cycle through the
// single read port of the table memory, with a read-modify-write pipeline
// of one stage; a switch or block item that finds a ready task then writes
// the winner back in ST_WIN_WR. The result waits in an output register;
// while the receiver stalls, the block finishes the current item and then
// holds s_axis_tready low until the result is taken. One item is in work
// at a time. Reset clears the ready bits (kept in flip-flops) and makes the
// idle task run; the table memory itself is not cleared, since slot data is
// only used once an add has written it and set its ready bit.
module aging_priority_task_scheduler_top
    import apts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF,
    parameter int PRIO_BITS  = PRIO_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // mode[2:0], task_req[6:3], priority_req[14:7]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // next_task[3:0], next_is_idle[4], switched[5]
);

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam int EW = 2 * PRIO_BITS + SKIP_BITS;
    localparam logic [SKIP_BITS-1:0] SKIP_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_WIN_RD, ST_WIN_WR, ST_OUT
    } state_t;

    typedef struct packed {
        logic [PRIO_BITS-1:0] sp;
        logic [PRIO_BITS-1:0] dp;
        logic [SKIP_BITS-1:0] skip;
    } entry_t;

    state_t state_reg;
    logic [TASK_SLOTS-1:0] ready_reg;
    logic [SW-1:0] run_slot_reg;
    logic run_idle_reg;
    logic [MODE_BITS-1:0] mode_reg;
    logic [CW-1:0] rd_cnt_reg;
    logic rd_vld_reg;
    logic [SW-1:0] rd_slot_reg;
    logic found_reg;
    logic [SW-1:0] best_reg;
    entry_t best_reg_e;
    logic [SW-1:0] old_slot_reg;
    logic old_idle_reg;
    logic out_valid_reg;
    logic [3:0] out_task_reg;
    logic out_idle_reg;
    logic out_sw_reg;

    logic wr_en;
    logic [SW-1:0] wr_addr;
    entry_t wr_data;
    logic [SW-1:0] rd_addr;
    entry_t rd_data;
    logic [EW-1:0] rd_raw;

    logic [MODE_BITS-1:0] in_mode;
    logic [REQ_SLOT_BITS-1:0] in_slot;
    logic [REQ_PRIO_BITS-1:0] in_prio;
    logic in_fire;
    logic slot_ok;
    logic [SW-1:0] slot_idx;

    assign in_mode = s_axis_tdata[2:0];
    assign in_slot = s_axis_tdata[6:3];
    assign in_prio = s_axis_tdata[14:7];
    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign slot_ok = ({28'd0, in_slot} < 32'(TASK_SLOTS));
    assign slot_idx = SW'(in_slot);
    assign rd_data = entry_t'(rd_raw);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_sw_reg, out_idle_reg, out_task_reg};

    apts_table #(.TASK_SLOTS(TASK_SLOTS), .PRIO_BITS(PRIO_BITS)) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (EW'(wr_data)),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    // Combinational scan step for the slot whose read data just returned.
    logic cur_ready;
    logic cur_aged;
    logic cand_take;
    logic cand_tie_cur_loses;
    entry_t best_cur;
    entry_t cur_e;
    logic [SKIP_BITS-1:0] bumped_best;

    always_comb
    begin
        cur_ready = rd_vld_reg && ready_reg[rd_slot_reg];
        cur_aged  = !(!run_idle_reg && rd_slot_reg == run_slot_reg);
        best_cur  = best_reg_e;
        cur_e     = rd_data;
        cand_take = 1'b0;
        cand_tie_cur_loses = 1'b0;
        bumped_best = (best_reg_e.skip != SKIP_MAX) ? best_reg_e.skip + 1'b1 : best_reg_e.skip;
        if (cur_ready && mode_reg != MODE_TICK)
        begin
            if (!found_reg)
            begin
                cand_take = 1'b1;
            end
            else if (best_reg_e.dp > rd_data.dp)
            begin
                cand_take = 1'b1;
            end
            else if (best_reg_e.dp == rd_data.dp)
            begin
                if (best_reg_e.skip < rd_data.skip)
                begin
                    cand_take = 1'b1;
                    best_cur.skip = bumped_best;
                end
                else
                begin
                    cand_tie_cur_loses = 1'b1;
                    if (rd_data.skip != SKIP_MAX)
                    begin
                        cur_e.skip = rd_data.skip + 1'b1;
                    end
                end
            end
        end
    end

    // Memory port control.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_slot_reg;
        wr_data = rd_data;
        rd_addr = SW'(rd_cnt_reg);
        if (in_fire && in_mode == MODE_ADD && slot_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_idx;
            wr_data.sp   = PRIO_BITS'(in_prio);
            wr_data.dp   = PRIO_BITS'(in_prio);
            wr_data.skip = '0;
        end
        else if (state_reg == ST_SCAN && cur_ready)
        begin
            if (mode_reg == MODE_TICK)
            begin
                if (cur_aged && rd_data.dp != '0)
                begin
                    wr_en   = 1'b1;
                    wr_data.dp = rd_data.dp - 1'b1;
                end
            end
            else if (cand_tie_cur_loses)
            begin
                wr_en   = 1'b1;
                wr_data = cur_e;
            end
            else if (cand_take && found_reg && best_reg_e.dp == rd_data.dp)
            begin
                // Previous candidate loses a tie: write its bumped count.
                wr_en   = 1'b1;
                wr_addr = best_reg;
                wr_data = best_cur;
            end
        end
        else if (state_reg == ST_WIN_WR)
        begin
            wr_en   = 1'b1;
            wr_addr = best_reg;
            wr_data.sp   = best_reg_e.sp;
            wr_data.dp   = best_reg_e.sp;
            wr_data.skip = '0;
        end
    end

    // Sequencer, scan pipeline and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ready_reg      <= '0;
            run_slot_reg   <= '0;
            run_idle_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
            rd_vld_reg     <= 1'b0;
            rd_cnt_reg     <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        mode_reg     <= in_mode;
                        old_slot_reg <= run_slot_reg;
                        old_idle_reg <= run_idle_reg;
                        rd_cnt_reg   <= '0;
                        rd_vld_reg   <= 1'b0;
                        found_reg    <= 1'b0;
                        if (in_mode == MODE_TICK || in_mode == MODE_SWITCH ||
                            in_mode == MODE_BLOCK)
                        begin
                            state_reg <= ST_SCAN;
                            if (in_mode == MODE_BLOCK && !run_idle_reg)
                            begin
                                ready_reg[run_slot_reg] <= 1'b0;
                            end
                        end
                        else
                        begin
                            if (in_mode == MODE_ADD && slot_ok)
                            begin
                                ready_reg[slot_idx] <= 1'b1;
                            end
                            if (in_mode == MODE_REMOVE && slot_ok)
                            begin
                                ready_reg[slot_idx] <= 1'b0;
                            end
                            out_task_reg  <= run_idle_reg ? 4'd0 : 4'(run_slot_reg);
                            out_idle_reg  <= run_idle_reg;
                            out_sw_reg    <= 1'b0;
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_SCAN:
                begin
                    rd_vld_reg  <= (rd_cnt_reg < CW'(TASK_SLOTS));
                    rd_slot_reg <= SW'(rd_cnt_reg);
                    if (rd_cnt_reg < CW'(TASK_SLOTS))
                    begin
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    end
                    if (cand_take)
                    begin
                        found_reg      <= 1'b1;
                        best_reg       <= rd_slot_reg;
                        best_reg_e     <= rd_data;
                    end
                    else if (cand_tie_cur_loses)
                    begin
                        best_reg_e <= best_cur;
                    end
                    else if (cur_ready && found_reg && best_reg_e.dp == rd_data.dp)
                    begin
                        best_reg_e <= best_cur;
                    end
                    if (!rd_vld_reg && rd_cnt_reg == CW'(TASK_SLOTS))
                    begin
                        state_reg <= ST_WIN_RD;
                    end
                end
                ST_WIN_RD:
                begin
                    if (mode_reg == MODE_TICK || !found_reg)
                    begin
                        if (mode_reg != MODE_TICK)
                        begin
                            run_slot_reg <= '0;
                            run_idle_reg <= 1'b1;
                        end
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_WIN_WR;
                    end
                end
                ST_WIN_WR:
                begin
                    run_slot_reg <= best_reg;
                    run_idle_reg <= 1'b0;
                    state_reg    <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_task_reg  <= run_idle_reg ? 4'd0 : 4'(run_slot_reg);
                        out_idle_reg  <= run_idle_reg;
                        out_sw_reg    <= (mode_reg != MODE_TICK) &&
                                         ((old_idle_reg != run_idle_reg) ||
                                          (!run_idle_reg && old_slot_reg != run_slot_reg));
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
